// ----- src/ntm_pkg.sv -----
// node id to mac table: shared types, request and status codes, default sizes
// no dependencies; used by every module of the block
`default_nettype none

package ntm_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int ID_W      = 8;
    localparam int MAC_W     = 48;
    localparam int COUNT_W   = 6;

    // request kinds
    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_DEL    = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ID_W-1:0]  node_id;
        logic [MAC_W-1:0] mac_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [MAC_W-1:0]   mac_out;
        logic [COUNT_W-1:0] entry_count;
    } res_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [MAC_W-1:0] mac;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ----- src/ntm_mem.sv -----
// node id to mac table: entry memory, one write and one registered read port
// depends on ntm_pkg for the entry type
`default_nettype none

module ntm_mem #(
    parameter int DEPTH = ntm_pkg::DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire ntm_pkg::entry_t              wdata,
    input  wire logic                         re,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output ntm_pkg::entry_t                   rdata
);

    ntm_pkg::entry_t mem [DEPTH];
    ntm_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/ntm_seq.sv -----
// node id to mac table: request sequencer, scans the used slots then writes back
// depends on ntm_pkg and drives the ports of ntm_mem
`default_nettype none

module ntm_seq #(
    parameter int DEPTH = ntm_pkg::DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire ntm_pkg::req_t                req,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output ntm_pkg::res_t                     res,
    output logic                              mem_we,
    output logic [$clog2(DEPTH)-1:0]          mem_waddr,
    output ntm_pkg::entry_t                   mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(DEPTH)-1:0]          mem_raddr,
    input  wire ntm_pkg::entry_t              mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ntm_pkg::seq_state_t state_reg, state_next;
    ntm_pkg::req_t       req_reg, req_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       addr_reg, addr_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pidx_reg, pidx_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [ntm_pkg::MAC_W-1:0] fmac_reg, fmac_next;
    ntm_pkg::entry_t     last_reg, last_next;
    ntm_pkg::res_t       res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ntm_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        addr_reg  <= addr_next;
        pidx_reg  <= pidx_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
        fmac_reg  <= fmac_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        pend_next  = 1'b0;
        pidx_next  = addr_reg[AW-1:0];
        found_next = found_reg;
        slot_next  = slot_reg;
        fmac_next  = fmac_reg;
        last_next  = last_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = '{id: req_reg.node_id, mac: req_reg.mac_value};
        mem_re     = 1'b0;
        mem_raddr  = addr_reg[AW-1:0];

        unique case (state_reg)
            ntm_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    addr_next  = '0;
                    found_next = 1'b0;
                    state_next = ntm_pkg::S_SCAN;
                end
            end

            ntm_pkg::S_SCAN:
            begin
                // one read per used slot, compare lands in the following cycle
                mem_re = (addr_reg < count_reg);
                if (mem_re)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                pend_next = mem_re;
                if (pend_reg)
                begin
                    if (mem_rdata.id == req_reg.node_id && !found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = pidx_reg;
                        fmac_next  = mem_rdata.mac;
                    end
                    if (CW'(pidx_reg) == count_reg - CW'(1))
                    begin
                        last_next = mem_rdata;
                    end
                end
                if (!mem_re)
                begin
                    state_next = ntm_pkg::S_DECIDE;
                end
            end

            ntm_pkg::S_DECIDE:
            begin
                res_next.status  = ntm_pkg::ST_IGNORED;
                res_next.mac_out = '0;
                case (req_reg.req_type)
                    ntm_pkg::REQ_SET:
                    begin
                        if (req_reg.node_id != '0 && req_reg.mac_value != '0)
                        begin
                            if (found_reg)
                            begin
                                mem_we          = 1'b1;
                                res_next.status = ntm_pkg::ST_OK;
                            end
                            else if (count_reg < CW'(DEPTH))
                            begin
                                mem_we          = 1'b1;
                                mem_waddr       = count_reg[AW-1:0];
                                count_next      = count_reg + CW'(1);
                                res_next.status = ntm_pkg::ST_OK;
                            end
                            else
                            begin
                                res_next.status = ntm_pkg::ST_FULL;
                            end
                        end
                    end
                    ntm_pkg::REQ_DEL:
                    begin
                        if (found_reg)
                        begin
                            // last entry moves into the freed slot
                            mem_we          = 1'b1;
                            mem_wdata       = last_reg;
                            count_next      = count_reg - CW'(1);
                            res_next.status = ntm_pkg::ST_OK;
                        end
                        else
                        begin
                            res_next.status = ntm_pkg::ST_NOT_FOUND;
                        end
                    end
                    ntm_pkg::REQ_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            res_next.mac_out = fmac_reg;
                            res_next.status  = ntm_pkg::ST_OK;
                        end
                        else
                        begin
                            res_next.status = ntm_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_next.status = ntm_pkg::ST_IGNORED;
                    end
                endcase
                res_next.entry_count = ntm_pkg::COUNT_W'(count_next);
                state_next = ntm_pkg::S_DONE;
            end

            ntm_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ntm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ntm_pkg::S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- src/node_id_to_mac_table.sv -----
// node id to mac table: top level with stream ports and the output register
// depends on ntm_pkg, ntm_seq and ntm_mem
`default_nettype none

// Keeps a packed table of up to DEPTH (node id, 48-bit MAC) pairs in one
// synchronous memory, slots 0 to count-1 in use. Each request on the slave
// stream is a set (tuser 0), a delete (1) or a lookup (2); every request
// gives exactly one result on the master stream. A set with node 0 or an
// all-zero MAC, and request code 3, report ignored; a set updates a matching
// entry, appends, or reports full. A delete moves the last entry into the
// freed slot. One request is worked at a time: the scan reads one used slot
// per cycle through the single memory read port, then the decide step writes
// back and forms the result. The result sits in an output register, so the
// next request is taken while the previous result still waits. The memory has
// no reset; slots beyond the count are never read. entry_count shows the count
// modulo 64.
module node_id_to_mac_table #(
    parameter int DEPTH = ntm_pkg::DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // node_id[7:0], mac_value[55:8]
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // mac_out[47:0], entry_count[53:48], zero pad
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);

    ntm_pkg::req_t   req;
    ntm_pkg::res_t   res;
    logic            res_valid;
    logic            res_ready;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    ntm_pkg::entry_t mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    ntm_pkg::entry_t mem_rdata;

    logic            m_valid_reg;
    ntm_pkg::res_t   m_data_reg;

    // unpack the request
    assign req.req_type  = s_axis_tuser;
    assign req.node_id   = s_axis_tdata[7:0];
    assign req.mac_value = s_axis_tdata[55:8];

    ntm_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // the sequencer serializes requests, so a read never overlaps a pending
    // write of the same slot and no forwarding is needed
    ntm_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: loads when empty or draining this cycle
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_data_reg.entry_count, m_data_reg.mac_out};
    assign m_axis_tuser  = m_data_reg.status;

endmodule

`default_nettype wire

// ----- src/ntm_checker.sv -----
// node id to mac table: port-level checks, bound to the top level
// depends on ntm_pkg and node_id_to_mac_table
`default_nettype none

module ntm_checker #(
    parameter int DEPTH = ntm_pkg::DEPTH_DEF
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // only a found lookup returns a mac
    a_mac_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[47:0] != 48'd0) |-> m_axis_tuser == ntm_pkg::ST_OK)
        else $error("mac_out nonzero with status other than ok");

    // count never exceeds the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (DEPTH >= 64 || m_axis_tdata[53:48] <= 6'(DEPTH)))
        else $error("entry_count beyond depth");

    // full is only reported with every slot in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ntm_pkg::ST_FULL) |->
            m_axis_tdata[53:48] == 6'(DEPTH))
        else $error("table full reported with free slots");

    // one request at a time: no back to back acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind node_id_to_mac_table ntm_checker #(.DEPTH(DEPTH)) u_ntm_checker (.*);

`default_nettype wire

// ----- sim/tb_node_id_to_mac_table.sv -----
// testbench for node_id_to_mac_table: directed and random set, delete and lookup requests
// keeps its own copy of the table, checks every result; needs ntm_pkg and the block's rtl
module tb_node_id_to_mac_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = ntm_pkg::DEPTH_DEF;
    // request code the block does not use; it must come back as ignored
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // idle time after the last result, sized from the table depth plus slack
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 12;
    localparam int PHASE_ITEMS = 212;
    localparam int MAX_REPORTS = 10;
    localparam logic [ntm_pkg::MAC_W-1:0] MAC_ONES = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // slave side: one request per handshake
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // node_id[7:0], mac_value[55:8]
    logic [1:0] s_axis_tuser = '0;    // req_type[1:0]

    // master side: one result per request
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // mac_out[47:0], entry_count[53:48], zero pad
    logic [1:0] m_axis_tuser;         // status[1:0]

    // shadow copy of the table, updated when a request is accepted
    logic [ntm_pkg::ID_W-1:0] shadow_ids [TABLE_DEPTH];
    logic [ntm_pkg::MAC_W-1:0] shadow_macs [TABLE_DEPTH];
    int shadow_count = 0;

    // results the block still owes, oldest first
    ntm_pkg::res_t owed_results [$];

    int mismatch_count = 0;
    // chance in a hundred that the sender idles or the receiver stalls in a cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    node_id_to_mac_table #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // applies one request to the shadow table and returns the result it must give
    function automatic ntm_pkg::res_t apply_to_shadow(
        input logic [1:0] kind,
        input logic [ntm_pkg::ID_W-1:0] id,
        input logic [ntm_pkg::MAC_W-1:0] mac);
        ntm_pkg::res_t res;
        int hit;
        hit = -1;
        res.status = ntm_pkg::ST_IGNORED;
        res.mac_out = '0;
        // first used slot holding this id wins
        for (int i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_ids[i] == id)
                hit = i;
        end
        case (kind)
            ntm_pkg::REQ_SET:
            begin
                if (id != '0 && mac != '0)
                begin
                    if (hit >= 0)
                    begin
                        shadow_macs[hit] = mac;
                        res.status = ntm_pkg::ST_OK;
                    end
                    else if (shadow_count < TABLE_DEPTH)
                    begin
                        shadow_ids[shadow_count] = id;
                        shadow_macs[shadow_count] = mac;
                        shadow_count++;
                        res.status = ntm_pkg::ST_OK;
                    end
                    else
                        res.status = ntm_pkg::ST_FULL;
                end
            end
            ntm_pkg::REQ_DEL:
            begin
                // the last used entry fills the freed slot
                if (hit >= 0)
                begin
                    shadow_ids[hit] = shadow_ids[shadow_count - 1];
                    shadow_macs[hit] = shadow_macs[shadow_count - 1];
                    shadow_count--;
                    res.status = ntm_pkg::ST_OK;
                end
                else
                    res.status = ntm_pkg::ST_NOT_FOUND;
            end
            ntm_pkg::REQ_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    res.mac_out = shadow_macs[hit];
                    res.status = ntm_pkg::ST_OK;
                end
                else
                    res.status = ntm_pkg::ST_NOT_FOUND;
            end
            default: res.status = ntm_pkg::ST_IGNORED;
        endcase
        res.entry_count = shadow_count[ntm_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // drives one request, holds it until accepted, then records what it must return;
    // entered and left at a rising edge
    task automatic send_request(input logic [1:0] kind,
                                input logic [ntm_pkg::ID_W-1:0] id,
                                input logic [ntm_pkg::MAC_W-1:0] mac,
                                output ntm_pkg::res_t owed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {mac, id};
        s_axis_tuser <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        owed = apply_to_shadow(kind, id, mac);
        owed_results.push_back(owed);
    endtask

    // lets every owed result come back, then idles for the settle time
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input ntm_pkg::res_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch (%s): status exp %0d got %0d, mac exp %h got %h, %s %0d got %0d",
                     $realtime, what, want.status, m_axis_tuser,
                     want.mac_out, m_axis_tdata[47:0], "count exp",
                     want.entry_count, m_axis_tdata[53:48]);
    endtask

    // result side: random stalls, and every accepted result against the oldest owed one
    always @(posedge clk)
    begin
        ntm_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (owed_results.size() == 0)
            begin
                want = '0;
                report_mismatch("no request outstanding", want);
            end
            else
            begin
                want = owed_results.pop_front();
                if (m_axis_tuser !== want.status || m_axis_tdata[47:0] !== want.mac_out
                    || m_axis_tdata[53:48] !== want.entry_count)
                    report_mismatch("wrong field", want);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // empty table, ignored sets, update, delete that moves the last entry,
    // delete of the last entry itself, node 0 and the unused request code
    task automatic test_special_cases();
        ntm_pkg::res_t owed;
        send_request(ntm_pkg::REQ_LOOKUP, 8'd5, '0, owed);
        send_request(ntm_pkg::REQ_DEL, 8'd5, '0, owed);
        send_request(ntm_pkg::REQ_SET, 8'd0, 48'h123, owed);
        send_request(ntm_pkg::REQ_SET, 8'd7, '0, owed);
        send_request(REQ_UNUSED, 8'd7, MAC_ONES, owed);
        send_request(ntm_pkg::REQ_SET, 8'd255, MAC_ONES, owed);
        send_request(ntm_pkg::REQ_SET, 8'd1, 48'h1, owed);
        send_request(ntm_pkg::REQ_SET, 8'd128, 48'h8000_0000_0000, owed);
        send_request(ntm_pkg::REQ_LOOKUP, 8'd255, '0, owed);
        send_request(ntm_pkg::REQ_SET, 8'd255, 48'hA5A5_5A5A_C3C3, owed);
        send_request(ntm_pkg::REQ_LOOKUP, 8'd255, '0, owed);
        send_request(ntm_pkg::REQ_LOOKUP, 8'd0, '0, owed);
        send_request(ntm_pkg::REQ_DEL, 8'd0, '0, owed);
        // slot 0 goes away, node 128 moves down into it
        send_request(ntm_pkg::REQ_DEL, 8'd255, '0, owed);
        send_request(ntm_pkg::REQ_LOOKUP, 8'd128, '0, owed);
        send_request(ntm_pkg::REQ_LOOKUP, 8'd1, '0, owed);
        send_request(ntm_pkg::REQ_DEL, 8'd1, '0, owed);
        send_request(ntm_pkg::REQ_LOOKUP, 8'd1, '0, owed);
        send_request(ntm_pkg::REQ_DEL, 8'd128, '0, owed);
        send_request(ntm_pkg::REQ_LOOKUP, 8'd128, MAC_ONES, owed);
        wait_for_results();
    endtask

    // bursts that lean toward sets or toward deletes, so the table fills up,
    // runs full and drains again; ids mostly from a small pool to get hits
    task automatic run_random_traffic(input int n_items);
        ntm_pkg::res_t owed;
        int done_items;
        int burst_left;
        int set_pct;
        int pick;
        logic [1:0] kind;
        logic [ntm_pkg::ID_W-1:0] id;
        logic [ntm_pkg::MAC_W-1:0] mac;
        done_items = 0;
        burst_left = 0;
        set_pct = 50;
        while (done_items < n_items)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(20, 60);
                case ($urandom_range(2))
                    0: set_pct = 15;
                    1: set_pct = 50;
                    default: set_pct = 90;
                endcase
            end
            burst_left--;

            pick = $urandom_range(99);
            if (pick < 2)
                kind = REQ_UNUSED;
            else if (pick < set_pct)
                kind = ntm_pkg::REQ_SET;
            else if (pick < set_pct + (100 - set_pct) / 2)
                kind = ntm_pkg::REQ_DEL;
            else
                kind = ntm_pkg::REQ_LOOKUP;

            pick = $urandom_range(99);
            if (pick < 3)
                id = '0;
            else if (pick < 18)
                id = 8'($urandom_range(255));
            else if (pick < 60 && shadow_count > 0)
                id = shadow_ids[$urandom_range(shadow_count - 1)];
            else
                id = 8'($urandom_range(1, 40));

            pick = $urandom_range(99);
            if (pick < 4)
                mac = '0;
            else if (pick < 8)
                mac = MAC_ONES;
            else
                mac = {16'($urandom), 32'($urandom)};

            send_request(kind, id, mac, owed);
            done_items++;
        end
        wait_for_results();
    endtask

    task automatic test_steady_traffic();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random_traffic(PHASE_ITEMS);
    endtask

    task automatic test_sparse_requests();
        send_idle_pct = 87;
        recv_stall_pct = 0;
        run_random_traffic(PHASE_ITEMS);
    endtask

    task automatic test_slow_consumer();
        send_idle_pct = 0;
        recv_stall_pct = 87;
        run_random_traffic(PHASE_ITEMS);
    endtask

    task automatic test_both_sides_idle();
        send_idle_pct = 26;
        recv_stall_pct = 26;
        run_random_traffic(PHASE_ITEMS);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_special_cases();
        test_steady_traffic();
        test_sparse_requests();
        test_slow_consumer();
        test_both_sides_idle();
        if (owed_results.size() != 0)
        begin
            mismatch_count += owed_results.size();
            $display("%0d results never arrived", owed_results.size());
        end
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", owed_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
